[hw/rtl/dq_pkg.sv]
// Shared types and codes for the double-ended queue unit.
// Holds the request and response word layouts, operation codes and status codes.
// Depends on nothing.
`default_nettype none

package dq_pkg;

    localparam int KIND_BITS  = 2;
    localparam int VALUE_BITS = 32;
    localparam int IDX_BITS   = 6;
    localparam int STAT_BITS  = 2;
    localparam int LEN_BITS   = 7;

    // Operation codes.
    localparam logic [KIND_BITS-1:0] KIND_PUT    = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_GET    = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_READ   = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_REMOVE = 2'd3;

    // End selection codes.
    localparam logic END_HEAD = 1'b0;
    localparam logic END_TAIL = 1'b1;

    // Status codes.
    localparam logic [STAT_BITS-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic                  end_sel;
        logic [VALUE_BITS-1:0] value;
        logic [IDX_BITS-1:0]   index;
    } t_req;

    typedef struct packed {
        logic [STAT_BITS-1:0]  status;
        logic [VALUE_BITS-1:0] word_out;
        logic [LEN_BITS-1:0]   length;
    } t_rsp;

endpackage

`default_nettype wire

[hw/rtl/double_ended_queue_unit.sv]
// Top level of the double-ended queue unit: a ring store of DEPTH words in one
// simple dual-port memory, driven by a small sequencer.
// Depends on dq_pkg for the request and response word layouts and the codes.
//
//  Channel   | Signals                 | Direction | Handshake
//  ----------+-------------------------+-----------+---------------------------------
//  request   | start, i_req, busy      | in        | taken when start=1 and busy=0
//  response  | o_valid, o_result       | out       | one-cycle strobe, cannot stall
//
// Steps per word: a put is written and answered from S_EXEC; a get or an
// indexed read that finds its word issues its read in S_EXEC and answers from
// S_RDWAIT with the registered read data; a get, read or remove that fails
// at once answers from S_EXEC. A remove walks the store one entry per cycle
// through a pipelined read and compare, then moves the words behind the match
// one entry per cycle and answers; when nothing matches, it answers once the
// last word is compared.
// Reset is synchronous and active low; it empties the queue at once and needs no
// clearing pass, since only entries written by an earlier put are ever read.
// The receiver cannot stall; each response is shown for exactly one cycle, and
// a new request may be accepted in that same cycle.
`default_nettype none

module double_ended_queue_unit #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    input  wire dq_pkg::t_req i_req,
    output logic              busy,
    output logic              o_valid,
    output dq_pkg::t_rsp      o_result
);

    // Ring position width and count width (count reaches DEPTH itself).
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    // Width used to compare the request index against the count.
    localparam int IW = (CW > dq_pkg::IDX_BITS) ? CW : dq_pkg::IDX_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SCAN,
        S_SHIFT
    } t_state;

    // The ring store: one write port and one registered read port.
    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] r_rd_data;

    t_state        r_state;
    dq_pkg::t_req  r_req;
    logic [PW-1:0] r_head;
    logic [CW-1:0] r_count;
    // Scan: next distance to issue. Shift: next source position to read.
    logic [CW-1:0] r_k;
    // Head distance of the word whose read data arrives this cycle (scan),
    // or the destination of the pending write (shift).
    logic [CW-1:0] r_pos;
    logic          r_pend;
    logic          r_wpend;
    logic          r_valid;
    dq_pkg::t_rsp  r_rsp;

    logic                 mem_we;
    logic [PW-1:0]        mem_wa;
    logic [WORD_BITS-1:0] mem_wd;
    logic                 mem_re;
    logic [PW-1:0]        mem_ra;

    logic                 is_tail;
    logic                 is_full;
    logic                 is_empty;
    logic                 idx_miss;
    logic [WORD_BITS-1:0] key;
    logic                 hit;
    logic [PW-1:0]        head_dec;
    logic [CW-1:0]        n_count_dec;

    // Ring position of the word at distance k from the head.
    function automatic logic [PW-1:0] f_slot(input logic [PW-1:0] head,
                                             input logic [CW-1:0] k);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(k);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return PW'(s);
    endfunction

    // Head distance of the word at distance k from the chosen end.
    function automatic logic [CW-1:0] f_from_head(input logic          tail,
                                                  input logic [CW-1:0] cnt,
                                                  input logic [CW-1:0] k);
        return tail ? (cnt - CW'(1) - k) : k;
    endfunction

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_rsp;

    assign is_tail     = (r_req.end_sel == dq_pkg::END_TAIL);
    assign is_full     = (r_count == CW'(DEPTH));
    assign is_empty    = (r_count == '0);
    assign idx_miss    = (IW'(r_req.index) >= IW'(r_count));
    assign key         = WORD_BITS'(r_req.value);
    assign hit         = r_pend && (r_rd_data == key);
    assign head_dec    = (r_head == '0) ? PW'(DEPTH - 1) : (r_head - PW'(1));
    assign n_count_dec = r_count - CW'(1);

    // Memory port control, decoded from the sequencer state.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = key;
        mem_re = 1'b0;
        mem_ra = '0;
        case (r_state)
            S_EXEC: begin
                case (r_req.kind)
                    dq_pkg::KIND_PUT: begin
                        if (!is_full) begin
                            mem_we = 1'b1;
                            mem_wa = is_tail ? f_slot(r_head, r_count) : head_dec;
                        end
                    end
                    dq_pkg::KIND_GET: begin
                        if (!is_empty) begin
                            mem_re = 1'b1;
                            mem_ra = is_tail ? f_slot(r_head, n_count_dec) : r_head;
                        end
                    end
                    dq_pkg::KIND_READ: begin
                        if (!idx_miss) begin
                            mem_re = 1'b1;
                            mem_ra = f_slot(r_head,
                                f_from_head(is_tail, r_count, CW'(r_req.index)));
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                // Keep one read in flight while the previous word is compared.
                if (!hit && (r_k < r_count)) begin
                    mem_re = 1'b1;
                    mem_ra = f_slot(r_head, f_from_head(is_tail, r_count, r_k));
                end
            end
            S_SHIFT: begin
                // Write the word read last cycle one place toward the head
                // while the next one is read; the two never hit the same entry.
                if (r_wpend) begin
                    mem_we = 1'b1;
                    mem_wa = f_slot(r_head, r_pos);
                    mem_wd = r_rd_data;
                end
                if (r_k < r_count) begin
                    mem_re = 1'b1;
                    mem_ra = f_slot(r_head, r_k);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    // Sequencer: state, queue pointers and the registered response.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_wpend <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req   <= i_req;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_rsp.status   <= dq_pkg::ST_OK;
                    r_rsp.word_out <= '0;
                    r_rsp.length   <= dq_pkg::LEN_BITS'(r_count);
                    case (r_req.kind)
                        dq_pkg::KIND_PUT: begin
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                            if (is_full) begin
                                r_rsp.status <= dq_pkg::ST_FULL;
                            end else begin
                                r_count      <= r_count + CW'(1);
                                r_rsp.length <= dq_pkg::LEN_BITS'(r_count + CW'(1));
                                if (!is_tail) begin
                                    r_head <= head_dec;
                                end
                            end
                        end
                        dq_pkg::KIND_GET: begin
                            if (is_empty) begin
                                r_rsp.status <= dq_pkg::ST_MISS;
                                r_valid      <= 1'b1;
                                r_state      <= S_IDLE;
                            end else begin
                                r_count <= n_count_dec;
                                if (!is_tail) begin
                                    r_head <= f_slot(r_head, CW'(1));
                                end
                                r_state <= S_RDWAIT;
                            end
                        end
                        dq_pkg::KIND_READ: begin
                            if (idx_miss) begin
                                r_rsp.status <= dq_pkg::ST_MISS;
                                r_valid      <= 1'b1;
                                r_state      <= S_IDLE;
                            end else begin
                                r_state <= S_RDWAIT;
                            end
                        end
                        default: begin
                            if (is_empty) begin
                                r_rsp.status <= dq_pkg::ST_MISS;
                                r_valid      <= 1'b1;
                                r_state      <= S_IDLE;
                            end else begin
                                r_k     <= '0;
                                r_pend  <= 1'b0;
                                r_state <= S_SCAN;
                            end
                        end
                    endcase
                end
                S_RDWAIT: begin
                    r_rsp.status   <= dq_pkg::ST_OK;
                    r_rsp.word_out <= dq_pkg::VALUE_BITS'(r_rd_data);
                    r_rsp.length   <= dq_pkg::LEN_BITS'(r_count);
                    r_valid        <= 1'b1;
                    r_state        <= S_IDLE;
                end
                S_SCAN: begin
                    if (hit) begin
                        // Matched word sits at head distance r_pos; words behind
                        // it move up starting with the one at r_pos + 1.
                        r_pend  <= 1'b0;
                        r_k     <= r_pos + CW'(1);
                        r_wpend <= 1'b0;
                        r_state <= S_SHIFT;
                    end else if (r_k < r_count) begin
                        r_pend <= 1'b1;
                        r_pos  <= f_from_head(is_tail, r_count, r_k);
                        r_k    <= r_k + CW'(1);
                    end else begin
                        // Last word compared without a match.
                        r_pend         <= 1'b0;
                        r_rsp.status   <= dq_pkg::ST_MISS;
                        r_rsp.word_out <= '0;
                        r_rsp.length   <= dq_pkg::LEN_BITS'(r_count);
                        r_valid        <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                S_SHIFT: begin
                    if (r_k < r_count) begin
                        r_wpend <= 1'b1;
                        r_pos   <= r_k - CW'(1);
                        r_k     <= r_k + CW'(1);
                    end else begin
                        // Any final pending write lands in this cycle.
                        r_wpend        <= 1'b0;
                        r_count        <= n_count_dec;
                        r_rsp.status   <= dq_pkg::ST_OK;
                        r_rsp.word_out <= dq_pkg::VALUE_BITS'(key);
                        r_rsp.length   <= dq_pkg::LEN_BITS'(n_count_dec);
                        r_valid        <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The count never passes the depth of the store.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count exceeds store depth");

    // A response is only issued as the sequencer returns to idle.
    a_resp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("response issued while sequencer busy");

    // An accepted request keeps the unit busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not make the unit busy");

    // A full status is only given when the store is full.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == dq_pkg::ST_FULL)) |-> is_full)
        else $error("full status with free entries");

    // Failed requests return a zero word.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status != dq_pkg::ST_OK)) |-> (o_result.word_out == '0))
        else $error("nonzero word on failed request");

    // No write to the store while idle or waiting on a read.
    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ((r_state == S_EXEC) || (r_state == S_SHIFT)))
        else $error("store written outside put or shift");

endmodule

`default_nettype wire

[bench/dq_response_checker.sv]
// Response checker for the double-ended queue unit: watches both channels, runs its own
// ring-store model of the queue and compares every response word field by field.
// Depends on dq_pkg for the request and response word layouts and the codes.
`timescale 1ns / 1ps

module dq_response_checker #(
    parameter int DEPTH = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic         i_busy,
    input  wire dq_pkg::t_req i_req,
    input  wire logic         i_valid,
    input  wire dq_pkg::t_rsp i_result,
    input  wire logic         i_wrap_up,
    output int                o_errors,
    output int                o_pending,
    output int                o_requests,
    output int                o_responses,
    output int                o_fulls,
    output int                o_misses,
    output int                o_remove_hits
);

    import dq_pkg::*;

    // Model state: ring of words, ring slot of the head word, number of stored words.
    logic [VALUE_BITS-1:0] ring [DEPTH];
    int unsigned           head_slot;
    int unsigned           used;

    t_rsp expected_rsp_q [$];
    t_rsp want;
    bit   wrapped;
    int   err_count;

    assign o_errors = err_count;

    task automatic report_error(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        err_count++;
    endtask

    function automatic int unsigned slot_at(input int unsigned k);
        return (head_slot + k) % DEPTH;
    endfunction

    function automatic int unsigned dist_from_head(input logic at_tail, input int unsigned k);
        return (at_tail == END_TAIL) ? (used - 1 - k) : k;
    endfunction

    // Applies one request word to the model and returns the response it must produce.
    function automatic t_rsp apply_request(input t_req r);
        t_rsp        rsp;
        int unsigned pos;
        bit          found;

        rsp.status   = ST_OK;
        rsp.word_out = '0;
        found        = 1'b0;
        pos          = 0;
        case (r.kind)
            KIND_PUT: begin
                if (used >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else if (r.end_sel == END_TAIL) begin
                    ring[slot_at(used)] = r.value;
                    used++;
                end else begin
                    head_slot       = (head_slot + DEPTH - 1) % DEPTH;
                    ring[head_slot] = r.value;
                    used++;
                end
            end
            KIND_GET: begin
                if (used == 0) begin
                    rsp.status = ST_MISS;
                end else if (r.end_sel == END_TAIL) begin
                    rsp.word_out = ring[slot_at(used - 1)];
                    used--;
                end else begin
                    rsp.word_out = ring[head_slot];
                    head_slot    = slot_at(1);
                    used--;
                end
            end
            KIND_READ: begin
                if (r.index >= used) begin
                    rsp.status = ST_MISS;
                end else begin
                    rsp.word_out = ring[slot_at(dist_from_head(r.end_sel, r.index))];
                end
            end
            default: begin
                for (int unsigned k = 0; k < used && !found; k++) begin
                    if (ring[slot_at(dist_from_head(r.end_sel, k))] == r.value) begin
                        pos   = dist_from_head(r.end_sel, k);
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    rsp.status = ST_MISS;
                end else begin
                    // The words behind the match close the gap toward the head.
                    rsp.word_out = ring[slot_at(pos)];
                    for (int unsigned k = pos; k + 1 < used; k++) begin
                        ring[slot_at(k)] = ring[slot_at(k + 1)];
                    end
                    used--;
                end
            end
        endcase
        rsp.length = used[LEN_BITS-1:0];
        return rsp;
    endfunction

    initial begin
        err_count     = 0;
        o_pending     = 0;
        o_requests    = 0;
        o_responses   = 0;
        o_fulls       = 0;
        o_misses      = 0;
        o_remove_hits = 0;
        wrapped       = 1'b0;
        head_slot     = 0;
        used          = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_slot = 0;
            used      = 0;
            expected_rsp_q.delete();
            o_pending <= 0;
        end else begin
            // A response always comes in a later cycle than its request, so check before predicting.
            if (i_valid) begin
                o_responses <= o_responses + 1;
                if (expected_rsp_q.size() == 0) begin
                    report_error($sformatf("response with none outstanding: %p", i_result));
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (i_result.status !== want.status)
                        report_error($sformatf("response %0d status: got %0d, expected %0d",
                                               o_responses, i_result.status, want.status));
                    if (i_result.word_out !== want.word_out)
                        report_error($sformatf("response %0d word_out: got %h, expected %h",
                                               o_responses, i_result.word_out, want.word_out));
                    if (i_result.length !== want.length)
                        report_error($sformatf("response %0d length: got %0d, expected %0d",
                                               o_responses, i_result.length, want.length));
                end
            end
            if (i_start && !i_busy) begin
                want = apply_request(i_req);
                expected_rsp_q.push_back(want);
                o_requests <= o_requests + 1;
                if (want.status == ST_FULL)
                    o_fulls <= o_fulls + 1;
                if (want.status == ST_MISS)
                    o_misses <= o_misses + 1;
                if (want.status == ST_OK && i_req.kind == KIND_REMOVE)
                    o_remove_hits <= o_remove_hits + 1;
            end
            if (i_wrap_up && !wrapped) begin
                wrapped = 1'b1;
                if (expected_rsp_q.size() != 0)
                    report_error($sformatf("%0d responses never arrived",
                                           expected_rsp_q.size()));
            end
            o_pending <= expected_rsp_q.size();
        end
    end

endmodule

[bench/tb_double_ended_queue_unit.sv]
// Testbench top for the double-ended queue unit: clock, reset, request stimulus and verdict.
// Depends on dq_pkg, double_ended_queue_unit and dq_response_checker, which does all checking.
`timescale 1ns / 1ps

module tb_double_ended_queue_unit;

    import dq_pkg::*;

    // How many random request words to send after the directed part.
    localparam int RANDOM_WORDS = 1200;
    // Cycles with no word moving on either channel before the run is called hung.
    // Legal quiet stretches include a long sender gap, a remove that walks and shifts
    // a full store, and the settling time at the end of the run.
    localparam int IDLE_LIMIT   = 4000;
    // Settling time after the last response, longer than a full-store remove.
    localparam int TAIL_CYCLES  = 200;

    typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED, PH_SEARCH} t_phase;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_valid;
    t_rsp o_result;

    logic wrap_up = 1'b0;
    int   err_count;
    int   pending;
    int   n_requests;
    int   n_responses;
    int   n_fulls;
    int   n_misses;
    int   n_remove_hits;

    int   idle_cycles = 0;
    int   directed_words = 0;
    int   random_words = 0;
    int   phase_count = 0;

    // A small set of words that puts and removes draw from, so that removes find
    // matches, duplicates exist, and the search direction matters.
    logic [VALUE_BITS-1:0] palette [8];

    double_ended_queue_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    dq_response_checker resp_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req         (i_req),
        .i_valid       (o_valid),
        .i_result      (o_result),
        .i_wrap_up     (wrap_up),
        .o_errors      (err_count),
        .o_pending     (pending),
        .o_requests    (n_requests),
        .o_responses   (n_responses),
        .o_fulls       (n_fulls),
        .o_misses      (n_misses),
        .o_remove_hits (n_remove_hits)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: any accepted request or any response strobe counts as progress.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] timeout: nothing moved for %0d cycles", $time, IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_req make_word(input logic [KIND_BITS-1:0] kind, input logic end_sel,
                                       input logic [VALUE_BITS-1:0] value,
                                       input logic [IDX_BITS-1:0] index);
        t_req w;
        w.kind    = kind;
        w.end_sel = end_sel;
        w.value   = value;
        w.index   = index;
        return w;
    endfunction

    // Mostly no gap, often a short one, now and then a long one. Quiet stretches
    // send back to back so the block runs at its own pace.
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VALUE_BITS-1:0] palette_or_random(input int palette_pct);
        if ($urandom_range(0, 99) < palette_pct)
            return palette[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // Builds one random request word. The phase sets the mix of operations so that
    // the store is driven up to full, down to empty, and searched in between.
    // Fields an operation does not use are still random.
    function automatic t_req random_word(input t_phase phase);
        t_req w;
        int   r;
        int   put_pct;
        int   get_pct;
        int   read_pct;

        case (phase)
            PH_GROW:   begin put_pct = 70; get_pct = 10; read_pct = 12; end
            PH_SHRINK: begin put_pct = 15; get_pct = 55; read_pct = 15; end
            PH_MIXED:  begin put_pct = 35; get_pct = 25; read_pct = 25; end
            default:   begin put_pct = 40; get_pct = 10; read_pct = 10; end
        endcase
        r         = $urandom_range(0, 99);
        w.end_sel = 1'($urandom_range(0, 1));
        w.index   = ($urandom_range(0, 1) != 0) ? IDX_BITS'($urandom_range(0, 7))
                                                : IDX_BITS'($urandom);
        if (r < put_pct) begin
            w.kind  = KIND_PUT;
            w.value = palette_or_random(50);
        end else if (r < put_pct + get_pct) begin
            w.kind  = KIND_GET;
            w.value = $urandom;
        end else if (r < put_pct + get_pct + read_pct) begin
            w.kind  = KIND_READ;
            w.value = $urandom;
        end else begin
            w.kind  = KIND_REMOVE;
            w.value = palette_or_random(75);
        end
        return w;
    endfunction

    // Offers one request word and holds it until the block takes it. A word is taken
    // at an edge where start is high and busy is low; busy is read just after the
    // edge, which still shows the value the block sampled. With no gap, start stays
    // high for the next word and is never lowered and raised in one step.
    task automatic send_word(input t_req w, input int gap);
        start <= 1'b1;
        i_req <= w;
        do @(posedge i_clk); while (busy);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops sending and waits for every outstanding response.
    task automatic drain_responses();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        t_req   directed [$];
        t_phase phase;
        int     phase_len;
        bit     quiet;

        palette[0] = '0;
        palette[1] = '1;
        for (int i = 2; i < 8; i++)
            palette[i] = $urandom;

        // Reset once, held from time zero and then released.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Every operation on an empty store first, then a short queue
        // of A5, FF, 0, 5A, FF (head to tail) to read at both ends and past the end,
        // remove duplicates from each side, miss on a remove, and empty it again.
        directed.push_back(make_word(KIND_GET,    END_HEAD, 32'h0,        6'd0));
        directed.push_back(make_word(KIND_GET,    END_TAIL, 32'hFFFFFFFF, 6'd63));
        directed.push_back(make_word(KIND_REMOVE, END_HEAD, 32'h0,        6'd0));
        directed.push_back(make_word(KIND_READ,   END_HEAD, 32'h0,        6'd0));
        directed.push_back(make_word(KIND_PUT,    END_HEAD, 32'hFFFFFFFF, 6'd63));
        directed.push_back(make_word(KIND_PUT,    END_TAIL, 32'h00000000, 6'd0));
        directed.push_back(make_word(KIND_PUT,    END_HEAD, 32'hA5A5A5A5, 6'd21));
        directed.push_back(make_word(KIND_PUT,    END_TAIL, 32'h5A5A5A5A, 6'd42));
        directed.push_back(make_word(KIND_PUT,    END_TAIL, 32'hFFFFFFFF, 6'd0));
        directed.push_back(make_word(KIND_READ,   END_HEAD, 32'h0,        6'd0));
        directed.push_back(make_word(KIND_READ,   END_TAIL, 32'hFFFFFFFF, 6'd0));
        directed.push_back(make_word(KIND_READ,   END_HEAD, 32'h0,        6'd4));
        directed.push_back(make_word(KIND_READ,   END_TAIL, 32'h0,        6'd5));
        directed.push_back(make_word(KIND_READ,   END_HEAD, 32'h0,        6'd63));
        directed.push_back(make_word(KIND_REMOVE, END_TAIL, 32'hFFFFFFFF, 6'd0));
        directed.push_back(make_word(KIND_REMOVE, END_HEAD, 32'hFFFFFFFF, 6'd63));
        directed.push_back(make_word(KIND_REMOVE, END_HEAD, 32'h12345678, 6'd0));
        directed.push_back(make_word(KIND_REMOVE, END_TAIL, 32'h00000000, 6'd0));
        directed.push_back(make_word(KIND_GET,    END_TAIL, 32'h0,        6'd0));
        directed.push_back(make_word(KIND_GET,    END_HEAD, 32'h0,        6'd0));
        directed.push_back(make_word(KIND_GET,    END_HEAD, 32'h0,        6'd0));
        directed.push_back(make_word(KIND_PUT,    END_TAIL, 32'h00000001, 6'd0));
        directed.push_back(make_word(KIND_REMOVE, END_HEAD, 32'h00000001, 6'd0));
        foreach (directed[i]) begin
            send_word(directed[i], pick_gap(1'b0));
            directed_words++;
        end
        drain_responses();

        // Random part in phases. The first phase fills the store past full and the
        // second empties it past empty; after that the phases are picked at random.
        // The sender drains all responses at the end of every phase.
        while (random_words < RANDOM_WORDS) begin
            if (phase_count == 0)
                phase = PH_GROW;
            else if (phase_count == 1)
                phase = PH_SHRINK;
            else
                phase = t_phase'($urandom_range(0, 3));
            phase_len = (phase_count < 2) ? 150 : $urandom_range(40, 150);
            quiet     = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < phase_len && random_words < RANDOM_WORDS; i++) begin
                send_word(random_word(phase), pick_gap(quiet));
                random_words++;
            end
            drain_responses();
            phase_count++;
        end

        // Let the block settle, then have the checker flag anything still owed.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        wrap_up <= 1'b1;
        repeat (2) @(posedge i_clk);

        $display("Sent %0d directed and %0d random request words in %0d phases.",
                 directed_words, random_words, phase_count);
        $display("Checked %0d responses: %0d full rejections, %0d misses, %0d remove hits.",
                 n_responses, n_fulls, n_misses, n_remove_hits);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
